[rtl/core/tbrl_pkg.sv]
// ----------------------------------------------------------------------------
// tbrl_pkg
// Shared types and constants for the token bucket rate limiter.
// ----------------------------------------------------------------------------
package tbrl_pkg;

  // Bucket slots; the count is a power of two so the slot is the low index bits
  localparam int NUM_BUCKETS = 256;
  localparam int SLOT_W      = $clog2(NUM_BUCKETS);

  // Field widths
  localparam int RATE_W  = 20;
  localparam int BURST_W = 16;
  localparam int LEVEL_W = 32;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 32;
  localparam int INDEX_W = 8;
  localparam int PROD_W  = RATE_W + TIME_W;
  localparam int SUM_W   = PROD_W + 1;

  // One token is held as this many level units
  localparam int UNITS_PER_TOKEN = 60000;
  localparam int QUOT_W          = 16;

  // Whole tokens: 60000 = 32 * 1875, so drop five bits, then multiply by
  // the rounded-up reciprocal of 1875 scaled by 2^38 (exact for 27-bit input)
  localparam int                 LVL_PRE_SHIFT = 5;
  localparam int                 RECIP_W       = 28;
  localparam logic [RECIP_W-1:0] RECIP_1875    = 28'd146601551;
  localparam int                 RECIP_SHIFT   = 38;
  localparam int                 QPROD_W       = RECIP_SHIFT + QUOT_W;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BURST = 1'b1;
  localparam int CFG_DATA_W = RATE_W;

  // Request kinds
  localparam logic MODE_CHECK = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Reset values of the registers
  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(60);
  localparam logic [BURST_W-1:0] BURST_RESET = BURST_W'(10);

  // Stream widths
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 56;

  // One bucket record as kept in the slot memory
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  last_ms;
    logic [COUNT_W-1:0] count;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ADD,
    ST_ADMIT,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

[rtl/core/tbrl_ram.sv]
// ----------------------------------------------------------------------------
// tbrl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tbrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/tbrl_div.sv]
// ----------------------------------------------------------------------------
// tbrl_div
// Whole-token count of a bucket level: division by the units per token done
// as a shift and one multiplication by a fixed reciprocal.
// ----------------------------------------------------------------------------
module tbrl_div
  import tbrl_pkg::*;
(
  input  logic [LEVEL_W-1:0] dividend,
  output logic [QUOT_W-1:0]  quotient
);

  logic [QPROD_W-1:0] prod;

  // Drop the factor of 32, then scale by the reciprocal of 1875
  assign prod     = QPROD_W'(dividend[LEVEL_W-1:LVL_PRE_SHIFT]) * QPROD_W'(RECIP_1875);
  assign quotient = prod[RECIP_SHIFT +: QUOT_W];

endmodule

[rtl/core/token_bucket_rate_limiter.sv]
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter
// Per-slot token bucket policer with bucket state held in a slot memory.
//
//   Channel  Dir  Fields (low bit first)
//   s_*      in   tuser: mode; tdata: bucket_index, now_ms
//   m_*      out  tdata: allowed, tokens_whole, admitted_count
//   cfg_*    in   index 0 rate_per_minute, index 1 burst_size
//
// An admission check raises m_tvalid after its input beat passes through
// memory read, multiply, refill add, admit and write back, reciprocal
// multiply for the whole-token count and the output register; a clear goes
// straight to the output register. One item is in flight at a time, so the
// input is held until the item is back in ST_IDLE; a result still waiting
// in the output register stalls the next item in ST_OUT. Reset clears the
// slot-in-use bits.
module token_bucket_rate_limiter
  import tbrl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_DATA_W-1:0]    s_tdata,   // bucket_index[7:0], now_ms[39:8]
  input  logic                   s_tuser,   // mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_DATA_W-1:0]    m_tdata,   // allowed[0], tokens_whole[16:1],
                                            // admitted_count[48:17], zero fill
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration
  logic [RATE_W-1:0]  rate;
  logic [BURST_W-1:0] burst;
  logic [LEVEL_W-1:0] cap;

  // Sequencer
  state_t state, state_next;
  logic   s_beat;
  logic   ram_re;
  logic   ram_we;
  logic   out_load;

  // Request
  logic [SLOT_W-1:0] req_slot;
  logic [TIME_W-1:0] req_now;
  logic [SLOT_W-1:0] in_slot;

  // Working values
  logic [NUM_BUCKETS-1:0] slot_used;
  slot_rec_t              rd_rec;
  slot_rec_t              wr_rec;
  logic [LEVEL_W-1:0]     lvl;
  logic [COUNT_W-1:0]     cnt;
  logic [TIME_W-1:0]      elapsed;
  logic [PROD_W-1:0]      prod;
  logic [SUM_W-1:0]       sum;
  logic                   admit;
  logic [LEVEL_W-1:0]     lvl_after;
  logic [COUNT_W-1:0]     cnt_after;
  logic [QUOT_W-1:0]      div_quot;

  // Result
  logic               res_allowed;
  logic [BURST_W-1:0] res_tokens;
  logic [COUNT_W-1:0] res_count;

  assign s_beat  = s_tvalid && s_tready;
  assign in_slot = SLOT_W'(s_tdata[INDEX_W-1:0]);

  // Configuration writes; the full level is formed at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      rate  <= RATE_RESET;
      burst <= BURST_RESET;
      cap   <= LEVEL_W'(BURST_RESET * UNITS_PER_TOKEN);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATE: begin
          rate <= cfg_wdata[RATE_W-1:0];
        end
        REG_BURST: begin
          burst <= cfg_wdata[BURST_W-1:0];
          cap   <= LEVEL_W'(cfg_wdata[BURST_W-1:0] * LEVEL_W'(UNITS_PER_TOKEN));
        end
        default: begin
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_beat) begin
          state_next = (s_tuser == MODE_CLEAR) ? ST_OUT : ST_READ;
        end
      end
      ST_READ:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_ADD;
      ST_ADD:   state_next = ST_ADMIT;
      ST_ADMIT: state_next = ST_DIV;
      ST_DIV:   state_next = ST_OUT;
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        ram_re   = s_tvalid;
      end
      ST_ADMIT: begin
        ram_we = 1'b1;
      end
      ST_OUT: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Slot memory
  tbrl_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_BUCKETS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req_slot),
    .wdata (wr_rec),
    .re    (ram_re),
    .raddr (in_slot),
    .rdata (rd_rec)
  );

  // Slot-in-use bits: drop on clear, set on write back
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
    end else if (s_beat && (s_tuser == MODE_CLEAR)) begin
      slot_used[in_slot] <= 1'b0;
    end else if (ram_we) begin
      slot_used[req_slot] <= 1'b1;
    end
  end

  // Refill arithmetic
  assign sum       = SUM_W'(lvl) + SUM_W'(prod);
  assign admit     = (lvl >= LEVEL_W'(UNITS_PER_TOKEN));
  assign lvl_after = admit ? lvl - LEVEL_W'(UNITS_PER_TOKEN) : lvl;
  assign cnt_after = (admit && (cnt != '1)) ? cnt + 1'b1 : cnt;

  always_comb begin
    wr_rec.level   = lvl_after;
    wr_rec.last_ms = req_now;
    wr_rec.count   = cnt_after;
  end

  // Capture the request, then load, refill and admit one stage at a time
  always_ff @(posedge clk) begin
    if (s_beat) begin
      req_slot <= in_slot;
      req_now  <= s_tdata[INDEX_W +: TIME_W];
    end
    unique case (state)
      ST_READ: begin
        if (slot_used[req_slot]) begin
          lvl     <= rd_rec.level;
          cnt     <= rd_rec.count;
          elapsed <= req_now - rd_rec.last_ms;
        end else begin
          lvl     <= cap;
          cnt     <= '0;
          elapsed <= '0;
        end
      end
      ST_MUL: begin
        prod <= rate * elapsed;
      end
      ST_ADD: begin
        if (elapsed != '0) begin
          lvl <= (sum > SUM_W'(cap)) ? cap : sum[LEVEL_W-1:0];
        end
      end
      ST_ADMIT: begin
        lvl <= lvl_after;
      end
      default: begin
      end
    endcase
  end

  // Whole tokens left
  tbrl_div u_div (
    .dividend (lvl),
    .quotient (div_quot)
  );

  // Hold the result until the output register takes it
  always_ff @(posedge clk) begin
    if (s_beat && (s_tuser == MODE_CLEAR)) begin
      res_allowed <= 1'b0;
      res_tokens  <= burst;
      res_count   <= '0;
    end else if (state == ST_ADMIT) begin
      res_allowed <= admit;
      res_count   <= cnt_after;
    end else if (state == ST_DIV) begin
      res_tokens <= div_quot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {M_DATA_W'(res_count) << (1 + BURST_W)}
               | {M_DATA_W'(res_tokens) << 1}
               | M_DATA_W'(res_allowed);
    end
  end

endmodule
